[rtl/core/tlnf_pkg.sv]
// ----------------------------------------------------------------------------
// tlnf_pkg
// Shared types, constants and rounding helpers for the line normal form block.
// ----------------------------------------------------------------------------
package tlnf_pkg;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int HALF_LENGTH      = 5;

   // per-request data that rides along the pipeline
   typedef struct packed {
      logic signed [31:0] x1;
      logic signed [31:0] y1;
      logic               neg_dx;
      logic               neg_dy;
      logic               degen;
   } side_type;

   // atan(2^-i), pi = 2^31
   function automatic logic signed [33:0] atan_lut(input logic [4:0] i);
      logic [31:0] v;
      case (i)
         5'd0:  v = 32'h20000000;
         5'd1:  v = 32'h12E4051D;
         5'd2:  v = 32'h09FB385B;
         5'd3:  v = 32'h051111D4;
         5'd4:  v = 32'h028B0D43;
         5'd5:  v = 32'h0145D7E1;
         5'd6:  v = 32'h00A2F61E;
         5'd7:  v = 32'h00517C55;
         5'd8:  v = 32'h0028BE53;
         5'd9:  v = 32'h00145F2E;
         5'd10: v = 32'h000A2F98;
         5'd11: v = 32'h000517CC;
         5'd12: v = 32'h00028BE6;
         5'd13: v = 32'h000145F3;
         5'd14: v = 32'h0000A2F9;
         5'd15: v = 32'h0000517C;
         5'd16: v = 32'h000028BE;
         5'd17: v = 32'h0000145F;
         5'd18: v = 32'h00000A2F;
         5'd19: v = 32'h00000517;
         5'd20: v = 32'h0000028B;
         5'd21: v = 32'h00000145;
         5'd22: v = 32'h000000A2;
         5'd23: v = 32'h00000051;
         5'd24: v = 32'h00000028;
         5'd25: v = 32'h00000014;
         5'd26: v = 32'h0000000A;
         5'd27: v = 32'h00000005;
         5'd28: v = 32'h00000002;
         5'd29: v = 32'h00000001;
         default: v = 32'h00000000;
      endcase
      return $signed({2'b00, v});
   endfunction

   // divide by 2^30, half away from zero: floor((v + 2^29 - neg) / 2^30)
   function automatic logic signed [37:0] rnd30(input logic signed [66:0] v);
      logic signed [66:0] s;
      s = v + 67'sd536870911 + $signed({66'd0, ~v[66]});
      return 38'(s >>> 30);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
      if (v > 38'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -38'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

endpackage

[rtl/core/two_point_line_normal_form.sv]
// ----------------------------------------------------------------------------
// two_point_line_normal_form
// Line through two Q16.16 points: unit normal, offset, angle/distance form
// and two end points five units either side of the foot point.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  req_    | in        | req_valid / req_stall | first_x/y, second_x/y
//  rsp_    | out       | rsp_valid / rsp_stall | normal, offset, angle, rho, ends
//
//  One request per cycle while the result is not stalled; the pipeline holds
//  the bit-per-stage square root (32 stages), the divider (31 stages) and one
//  stage per CORDIC step.
//  Reset (synchronous) clears the valid bits only.
//  A stalled result freezes the whole pipeline; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module two_point_line_normal_form
   import tlnf_pkg::*;
#(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_first_x,
   input  logic signed [31:0] req_first_y,
   input  logic signed [31:0] req_second_x,
   input  logic signed [31:0] req_second_y,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_normal_a,
   output logic signed [31:0] rsp_normal_b,
   output logic signed [31:0] rsp_offset_c,
   output logic signed [15:0] rsp_angle_theta,
   output logic        [30:0] rsp_distance_rho,
   output logic signed [31:0] rsp_near_end_x,
   output logic signed [31:0] rsp_near_end_y,
   output logic signed [31:0] rsp_far_end_x,
   output logic signed [31:0] rsp_far_end_y,
   output logic               rsp_degenerate
);

   localparam int SQ_STEPS  = 32;
   localparam int DIV_STEPS = 31;
   localparam int LAT       = 5 + SQ_STEPS + 1 + DIV_STEPS + 2 + CORDIC_STEPS + 4;

   logic           en;
   logic [LAT-1:0] vld_ff;

   // whole pipe advances unless the result is held
   assign en        = !(vld_ff[LAT-1] && rsp_stall);
   assign req_stall = !en;
   assign rsp_valid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], req_valid};
      end
   end

   // ---- S1: difference and magnitudes ----
   side_type    s1_sd_ff;
   logic [31:0] s1_ux_ff, s1_uy_ff;
   logic signed [32:0] dx_in, dy_in;

   assign dx_in = 33'(req_second_x) - 33'(req_first_x);
   assign dy_in = 33'(req_second_y) - 33'(req_first_y);

   always_ff @(posedge clock) begin
      if (en) begin
         s1_sd_ff.x1     <= req_first_x;
         s1_sd_ff.y1     <= req_first_y;
         s1_sd_ff.neg_dx <= dx_in[32];
         s1_sd_ff.neg_dy <= dy_in[32];
         s1_sd_ff.degen  <= (dx_in == '0) && (dy_in == '0);
         s1_ux_ff <= dx_in[32] ? 32'(-dx_in) : 32'(dx_in);
         s1_uy_ff <= dy_in[32] ? 32'(-dy_in) : 32'(dy_in);
      end
   end

   // ---- S2: leading zero count of the larger magnitude ----
   side_type    s2_sd_ff;
   logic [31:0] s2_ux_ff, s2_uy_ff;
   logic        s2_rt_ff;
   logic [4:0]  s2_sh_ff;
   logic [31:0] mx_in;
   logic [4:0]  sh_in;

   assign mx_in = (s1_ux_ff > s1_uy_ff) ? s1_ux_ff : s1_uy_ff;

   always_comb begin
      sh_in = '0;
      for (int i = 0; i < 31; i++) begin
         if (mx_in[i]) sh_in = 5'(30 - i);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_sd_ff <= s1_sd_ff;
         s2_ux_ff <= s1_ux_ff;
         s2_uy_ff <= s1_uy_ff;
         s2_rt_ff <= mx_in[31];
         s2_sh_ff <= sh_in;
      end
   end

   // ---- S3: scale so the larger lies in [2^30, 2^31) ----
   side_type    s3_sd_ff;
   logic [30:0] s3_ux_ff, s3_uy_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s3_sd_ff <= s2_sd_ff;
         s3_ux_ff <= s2_rt_ff ? s2_ux_ff[31:1] : 31'(s2_ux_ff << s2_sh_ff);
         s3_uy_ff <= s2_rt_ff ? s2_uy_ff[31:1] : 31'(s2_uy_ff << s2_sh_ff);
      end
   end

   // ---- S4: squares ----
   side_type    s4_sd_ff;
   logic [30:0] s4_ux_ff, s4_uy_ff;
   logic [61:0] s4_xx_ff, s4_yy_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s4_sd_ff <= s3_sd_ff;
         s4_ux_ff <= s3_ux_ff;
         s4_uy_ff <= s3_uy_ff;
         s4_xx_ff <= s3_ux_ff * s3_ux_ff;
         s4_yy_ff <= s3_uy_ff * s3_uy_ff;
      end
   end

   // ---- isqrt: index 0 is the sum stage, then one result bit per stage ----
   side_type    sq_sd_ff [0:SQ_STEPS];
   logic [30:0] sq_ux_ff [0:SQ_STEPS];
   logic [30:0] sq_uy_ff [0:SQ_STEPS];
   logic [62:0] sq_v_ff  [0:SQ_STEPS];
   logic [62:0] sq_r_ff  [0:SQ_STEPS];

   always_ff @(posedge clock) begin
      if (en) begin
         sq_sd_ff[0] <= s4_sd_ff;
         sq_ux_ff[0] <= s4_ux_ff;
         sq_uy_ff[0] <= s4_uy_ff;
         sq_v_ff[0]  <= 63'(s4_xx_ff) + 63'(s4_yy_ff);
         sq_r_ff[0]  <= '0;
      end
   end

   for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
      localparam logic [63:0] BITV = 64'(1) << (62 - 2 * i);
      logic [63:0] t_in;
      assign t_in = 64'(sq_r_ff[i]) + BITV;
      always_ff @(posedge clock) begin
         if (en) begin
            sq_sd_ff[i+1] <= sq_sd_ff[i];
            sq_ux_ff[i+1] <= sq_ux_ff[i];
            sq_uy_ff[i+1] <= sq_uy_ff[i];
            if (64'(sq_v_ff[i]) >= t_in) begin
               sq_v_ff[i+1] <= 63'(64'(sq_v_ff[i]) - t_in);
               sq_r_ff[i+1] <= (sq_r_ff[i] >> 1) + BITV[62:0];
            end else begin
               sq_v_ff[i+1] <= sq_v_ff[i];
               sq_r_ff[i+1] <= sq_r_ff[i] >> 1;
            end
         end
      end
   end

   // ---- divider: index 0 forms the rounded numerators ----
   side_type    dv_sd_ff [0:DIV_STEPS];
   logic [31:0] dv_n_ff  [0:DIV_STEPS];
   logic [62:0] dv_ra_ff [0:DIV_STEPS];
   logic [62:0] dv_rb_ff [0:DIV_STEPS];
   logic [30:0] dv_qa_ff [0:DIV_STEPS];
   logic [30:0] dv_qb_ff [0:DIV_STEPS];
   logic [31:0] n_in;

   assign n_in = sq_r_ff[SQ_STEPS][31:0];

   always_ff @(posedge clock) begin
      if (en) begin
         dv_sd_ff[0] <= sq_sd_ff[SQ_STEPS];
         dv_n_ff[0]  <= n_in;
         dv_ra_ff[0] <= (63'(sq_uy_ff[SQ_STEPS]) << 30) + 63'(n_in >> 1);
         dv_rb_ff[0] <= (63'(sq_ux_ff[SQ_STEPS]) << 30) + 63'(n_in >> 1);
         dv_qa_ff[0] <= '0;
         dv_qb_ff[0] <= '0;
      end
   end

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      localparam int J = DIV_STEPS - 1 - k;
      logic [62:0] d_in;
      logic        ga_in, gb_in;
      assign d_in  = 63'(dv_n_ff[k]) << J;
      assign ga_in = dv_ra_ff[k] >= d_in;
      assign gb_in = dv_rb_ff[k] >= d_in;
      always_ff @(posedge clock) begin
         if (en) begin
            dv_sd_ff[k+1] <= dv_sd_ff[k];
            dv_n_ff[k+1]  <= dv_n_ff[k];
            dv_ra_ff[k+1] <= ga_in ? dv_ra_ff[k] - d_in : dv_ra_ff[k];
            dv_rb_ff[k+1] <= gb_in ? dv_rb_ff[k] - d_in : dv_rb_ff[k];
            dv_qa_ff[k+1] <= dv_qa_ff[k] | (31'(ga_in) << J);
            dv_qb_ff[k+1] <= dv_qb_ff[k] | (31'(gb_in) << J);
         end
      end
   end

   // ---- signed normal ----
   side_type           ab_sd_ff;
   logic signed [31:0] ab_a_ff, ab_b_ff;
   logic signed [31:0] ua_in, ub_in;

   assign ua_in = $signed({1'b0, dv_qa_ff[DIV_STEPS]});
   assign ub_in = $signed({1'b0, dv_qb_ff[DIV_STEPS]});

   always_ff @(posedge clock) begin
      if (en) begin
         ab_sd_ff <= dv_sd_ff[DIV_STEPS];
         ab_a_ff  <= dv_sd_ff[DIV_STEPS].neg_dy ? -ua_in : ua_in;
         ab_b_ff  <= dv_sd_ff[DIV_STEPS].neg_dx ? ub_in : -ub_in;
      end
   end

   // ---- CORDIC atan2(b, a): index 0 is the quadrant fold ----
   side_type           cr_sd_ff [0:CORDIC_STEPS];
   logic signed [31:0] cr_a_ff  [0:CORDIC_STEPS];
   logic signed [31:0] cr_b_ff  [0:CORDIC_STEPS];
   logic signed [33:0] cr_x_ff  [0:CORDIC_STEPS];
   logic signed [33:0] cr_y_ff  [0:CORDIC_STEPS];
   logic signed [33:0] cr_z_ff  [0:CORDIC_STEPS];
   logic signed [33:0] xa_in, yb_in;

   assign xa_in = 34'(ab_a_ff);
   assign yb_in = 34'(ab_b_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         cr_sd_ff[0] <= ab_sd_ff;
         cr_a_ff[0]  <= ab_a_ff;
         cr_b_ff[0]  <= ab_b_ff;
         if (!xa_in[33]) begin
            cr_x_ff[0] <= xa_in;
            cr_y_ff[0] <= yb_in;
            cr_z_ff[0] <= '0;
         end else if (!yb_in[33]) begin
            cr_x_ff[0] <= yb_in;
            cr_y_ff[0] <= -xa_in;
            cr_z_ff[0] <= 34'sd1 <<< 30;
         end else begin
            cr_x_ff[0] <= -yb_in;
            cr_y_ff[0] <= xa_in;
            cr_z_ff[0] <= -(34'sd1 <<< 30);
         end
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      logic signed [33:0] xs_in, ys_in, at_in;
      logic               up_in;
      assign xs_in = cr_x_ff[i] >>> i;
      assign ys_in = cr_y_ff[i] >>> i;
      assign at_in = atan_lut(5'(i));
      assign up_in = (cr_y_ff[i] > 0);
      always_ff @(posedge clock) begin
         if (en) begin
            cr_sd_ff[i+1] <= cr_sd_ff[i];
            cr_a_ff[i+1]  <= cr_a_ff[i];
            cr_b_ff[i+1]  <= cr_b_ff[i];
            cr_x_ff[i+1]  <= up_in ? cr_x_ff[i] + ys_in : cr_x_ff[i] - ys_in;
            cr_y_ff[i+1]  <= up_in ? cr_y_ff[i] - xs_in : cr_y_ff[i] + xs_in;
            cr_z_ff[i+1]  <= up_in ? cr_z_ff[i] + at_in : cr_z_ff[i] - at_in;
         end
      end
   end

   // ---- P: offset products, angle rounded to 16 bits ----
   side_type           p_sd_ff;
   logic signed [31:0] p_a_ff, p_b_ff;
   logic signed [63:0] p_ax_ff, p_by_ff;
   logic        [15:0] p_th_ff;
   logic signed [33:0] zr_in;

   assign zr_in = (cr_z_ff[CORDIC_STEPS] + 34'sd32768) >>> 16;

   always_ff @(posedge clock) begin
      if (en) begin
         p_sd_ff <= cr_sd_ff[CORDIC_STEPS];
         p_a_ff  <= cr_a_ff[CORDIC_STEPS];
         p_b_ff  <= cr_b_ff[CORDIC_STEPS];
         p_ax_ff <= cr_a_ff[CORDIC_STEPS] * cr_sd_ff[CORDIC_STEPS].x1;
         p_by_ff <= cr_b_ff[CORDIC_STEPS] * cr_sd_ff[CORDIC_STEPS].y1;
         p_th_ff <= zr_in[15:0];
      end
   end

   // ---- C: offset rounded, angle turn, distance ----
   side_type           c_sd_ff;
   logic signed [31:0] c_a_ff, c_b_ff, c_off_ff;
   logic signed [34:0] c_c_ff;
   logic        [15:0] c_th_ff;
   logic        [30:0] c_rho_ff;
   logic signed [66:0] cf_in;
   logic signed [37:0] cr_in, ra_in;

   assign cf_in = -67'(p_ax_ff) - 67'(p_by_ff);
   assign cr_in = rnd30(cf_in);
   assign ra_in = cr_in[37] ? -cr_in : cr_in;

   always_ff @(posedge clock) begin
      if (en) begin
         c_sd_ff  <= p_sd_ff;
         c_a_ff   <= p_a_ff;
         c_b_ff   <= p_b_ff;
         c_c_ff   <= 35'(cr_in);
         c_off_ff <= sat32(cr_in);
         c_th_ff  <= cr_in[37] ? p_th_ff : p_th_ff + 16'h8000;
         c_rho_ff <= (ra_in > 38'sd2147483647) ? 31'h7FFFFFFF : ra_in[30:0];
      end
   end

   // ---- M: foot point in Q.46 ----
   side_type           m_sd_ff;
   logic signed [31:0] m_a_ff, m_b_ff, m_off_ff;
   logic        [15:0] m_th_ff;
   logic        [30:0] m_rho_ff;
   logic signed [66:0] m_mx_ff, m_my_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         m_sd_ff  <= c_sd_ff;
         m_a_ff   <= c_a_ff;
         m_b_ff   <= c_b_ff;
         m_off_ff <= c_off_ff;
         m_th_ff  <= c_th_ff;
         m_rho_ff <= c_rho_ff;
         m_mx_ff  <= -(67'(c_c_ff) * 67'(c_a_ff));
         m_my_ff  <= -(67'(c_c_ff) * 67'(c_b_ff));
      end
   end

   // ---- O: end points, output register ----
   logic signed [66:0] f5a_in, f5b_in, ea_in, eb_in;
   logic               z_in;

   // 5 * 2^16 = 2^18 + 2^16
   assign ea_in  = 67'(m_a_ff);
   assign eb_in  = 67'(m_b_ff);
   assign f5a_in = (ea_in <<< 18) + (ea_in <<< 16);
   assign f5b_in = (eb_in <<< 18) + (eb_in <<< 16);
   assign z_in   = m_sd_ff.degen;

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_degenerate   <= z_in;
         rsp_normal_a     <= z_in ? '0 : m_a_ff;
         rsp_normal_b     <= z_in ? '0 : m_b_ff;
         rsp_offset_c     <= z_in ? '0 : m_off_ff;
         rsp_angle_theta  <= z_in ? '0 : $signed(m_th_ff);
         rsp_distance_rho <= z_in ? '0 : m_rho_ff;
         rsp_near_end_x   <= z_in ? '0 : sat32(rnd30(m_mx_ff + f5b_in));
         rsp_near_end_y   <= z_in ? '0 : sat32(rnd30(m_my_ff - f5a_in));
         rsp_far_end_x    <= z_in ? '0 : sat32(rnd30(m_mx_ff - f5b_in));
         rsp_far_end_y    <= z_in ? '0 : sat32(rnd30(m_my_ff + f5a_in));
      end
   end

   // ---- checks ----
   a_rst_clear: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
         rsp_normal_a == 0 && rsp_normal_b == 0 && rsp_distance_rho == 0)
      else $error("degenerate result not zero");

   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_normal_a <= 32'sd1073741824 && rsp_normal_a >= -32'sd1073741824
         && rsp_normal_b <= 32'sd1073741824 && rsp_normal_b >= -32'sd1073741824)
      else $error("normal out of unit range");

   a_rho_neg_c: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_offset_c < 0 && rsp_offset_c != 32'sh80000000 |->
         32'(rsp_distance_rho) == -rsp_offset_c)
      else $error("rho does not match negative offset");

endmodule

[test/two_point_line_normal_form_tb.sv]
// ----------------------------------------------------------------------------
// two_point_line_normal_form_tb
// Drives random and corner point pairs through the line normal form block and
// compares every result field against an in-bench fixed-point predictor.
// ----------------------------------------------------------------------------
module two_point_line_normal_form_tb;

   typedef struct {
      logic signed [31:0] a;
      logic signed [31:0] b;
      logic signed [31:0] c;
      logic signed [15:0] theta;
      logic        [30:0] rho;
      logic signed [31:0] nx;
      logic signed [31:0] ny;
      logic signed [31:0] fx;
      logic signed [31:0] fy;
      logic               degen;
   } line_type;

   localparam int STEPS    = 16;
   localparam int WATCHDOG = 20000;

   // atan(2^-i), pi = 2^31
   function automatic longint atan_step(input int i);
      longint t[16] = '{64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4,
                        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
                        64'h0028BE53, 64'h00145F2E, 64'h000A2F98, 64'h000517CC,
                        64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C};
      return t[i];
   endfunction

   // divide by 2^30, half away from zero (operands stay well inside 64 bits)
   function automatic longint round30(input longint v);
      longint unsigned m;
      m = v < 0 ? -v : v;
      m = (m + (64'd1 << 29)) >> 30;
      return v < 0 ? -longint'(m) : longint'(m);
   endfunction

   function automatic logic signed [31:0] clip32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic longint unsigned root64(input longint unsigned v);
      longint unsigned r, bitv;
      r = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= r + bitv) begin
            v -= r + bitv;
            r = (r >> 1) + bitv;
         end else begin
            r >>= 1;
         end
         bitv >>= 2;
      end
      return r;
   endfunction

   // atan2 by CORDIC, 16-bit binary angle; >>> on longint is a floor shift
   function automatic logic [15:0] normal_angle(input longint x, input longint y);
      longint z, t, xs, ys;
      longint r;
      z = 0;
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; z = 64'sd1 << 30;
         end else begin
            t = x; x = -y; y = t; z = -(64'sd1 << 30);
         end
      end
      for (int i = 0; i < STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x = x + ys; y = y - xs; z += atan_step(i);
         end else begin
            x = x - ys; y = y + xs; z -= atan_step(i);
         end
      end
      r = (z + 32768) >>> 16;
      return r[15:0];
   endfunction

   function automatic line_type predict_line(input logic signed [31:0] x1,
         input logic signed [31:0] y1, input logic signed [31:0] x2,
         input logic signed [31:0] y2);
      line_type o;
      longint dx, dy, a, b, c, rho, mx, my, f5a, f5b;
      longint unsigned ux, uy, m, n, ua, ub;
      logic [15:0] th;
      o = '{default: '0};
      dx = longint'(x2) - longint'(x1);
      dy = longint'(y2) - longint'(y1);
      if (dx == 0 && dy == 0) begin
         o.degen = 1'b1;
         return o;
      end
      ux = dx < 0 ? -dx : dx;
      uy = dy < 0 ? -dy : dy;
      m = ux > uy ? ux : uy;
      if (m >= (64'd1 << 31)) begin
         ux >>= 1; uy >>= 1; m >>= 1;
      end
      while (m < (64'd1 << 30)) begin
         ux <<= 1; uy <<= 1; m <<= 1;
      end
      n = root64(ux * ux + uy * uy);
      ua = ((uy << 30) + (n >> 1)) / n;
      ub = ((ux << 30) + (n >> 1)) / n;
      a = dy < 0 ? -longint'(ua) : longint'(ua);
      b = dx < 0 ? longint'(ub) : -longint'(ub);
      c = round30(-a * longint'(x1) - b * longint'(y1));
      th = normal_angle(a, b);
      if (c >= 0) begin
         rho = c;
         th = th + 16'h8000;
      end else begin
         rho = -c;
      end
      if (rho > 64'sd2147483647) rho = 64'sd2147483647;
      mx = -c * a;
      my = -c * b;
      f5a = 5 * a * 65536;
      f5b = 5 * b * 65536;
      o.a = a[31:0];
      o.b = b[31:0];
      o.c = clip32(c);
      o.theta = th;
      o.rho = rho[30:0];
      o.nx = clip32(round30(mx + f5b));
      o.ny = clip32(round30(my - f5a));
      o.fx = clip32(round30(mx - f5b));
      o.fy = clip32(round30(my + f5a));
      return o;
   endfunction

   // FIFO of predicted lines, checked in order against the response port
   class line_board;
      line_type pending[$];
      int       errors = 0;

      function void note_request(input logic signed [31:0] x1, y1, x2, y2);
         pending.push_back(predict_line(x1, y1, x2, y2));
      endfunction

      function void check_line(input line_type got);
         line_type exp;
         if (pending.size() == 0) begin
            $display("%0t unexpected response", $realtime);
            errors++;
            return;
         end
         exp = pending.pop_front();
         if (got.a !== exp.a) flag("normal_a", exp.a, got.a);
         if (got.b !== exp.b) flag("normal_b", exp.b, got.b);
         if (got.c !== exp.c) flag("offset_c", exp.c, got.c);
         if (got.theta !== exp.theta) flag("angle_theta", exp.theta, got.theta);
         if (got.rho !== exp.rho) flag("distance_rho", exp.rho, got.rho);
         if (got.nx !== exp.nx) flag("near_end_x", exp.nx, got.nx);
         if (got.ny !== exp.ny) flag("near_end_y", exp.ny, got.ny);
         if (got.fx !== exp.fx) flag("far_end_x", exp.fx, got.fx);
         if (got.fy !== exp.fy) flag("far_end_y", exp.fy, got.fy);
         if (got.degen !== exp.degen) flag("degenerate", exp.degen, got.degen);
      endfunction

      function void flag(input string what, input logic [31:0] e, g);
         $display("%0t %s mismatch: expected %h actual %h", $realtime, what, e, g);
         errors++;
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [31:0] req_first_x = '0;
   logic signed [31:0] req_first_y = '0;
   logic signed [31:0] req_second_x = '0;
   logic signed [31:0] req_second_y = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_normal_a, rsp_normal_b, rsp_offset_c;
   logic signed [15:0] rsp_angle_theta;
   logic        [30:0] rsp_distance_rho;
   logic signed [31:0] rsp_near_end_x, rsp_near_end_y, rsp_far_end_x, rsp_far_end_y;
   logic               rsp_degenerate;

   line_board board = new();
   int        idle_cycles = 0;
   bit        stall_burst = 0;

   always #5 clock = ~clock;

   two_point_line_normal_form DUT (.*);

   // receiver: alternates long quiet stretches with stretches of random stalls
   always @(posedge clock) begin
      if ($urandom_range(0, 63) == 0) stall_burst <= ~stall_burst;
      rsp_stall <= stall_burst ? ($urandom_range(0, 2) != 0) : 1'b0;
   end

   // result check and stall-free watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            board.check_line('{rsp_normal_a, rsp_normal_b, rsp_offset_c,
               rsp_angle_theta, rsp_distance_rho, rsp_near_end_x, rsp_near_end_y,
               rsp_far_end_x, rsp_far_end_y, rsp_degenerate});
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG) begin
            $display("[two_point_line_normal_form] ERROR");
            $finish;
         end
      end
   end

   // one request, held until taken; valid stays high if the next one follows
   task automatic send_points(input logic signed [31:0] x1, y1, x2, y2,
                              input bit keep_valid);
      req_valid    <= 1'b1;
      req_first_x  <= x1;
      req_first_y  <= y1;
      req_second_x <= x2;
      req_second_y <= y2;
      do @(posedge clock); while (req_stall);
      board.note_request(x1, y1, x2, y2);
      if (!keep_valid) req_valid <= 1'b0;
   endtask

   // mostly small coordinates for tight rounding, some full range for saturation
   function automatic logic signed [31:0] pick_coord();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return $signed($urandom_range(0, 2000)) - 1000;
         2: return ($signed($urandom_range(0, 200)) - 100) <<< 16;
         3: return $urandom_range(0, 1) ? 32'sh7FFFFFFF - $urandom_range(0, 3)
                                        : 32'sh80000000 + $urandom_range(0, 3);
         default: return $signed($urandom()) >>> $urandom_range(0, 31);
      endcase
   endfunction

   initial begin
      logic signed [31:0] x1, y1, x2, y2;
      int gap, run;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // corners: coincident points, axis lines, extremes, line through origin
      send_points(0, 0, 0, 0, 1);
      send_points(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 1);
      send_points(0, 0, 32'sh10000, 0, 1);
      send_points(0, 0, -32'sh10000, 0, 1);
      send_points(0, 0, 0, 32'sh10000, 1);
      send_points(0, 0, 0, -32'sh10000, 1);
      send_points(32'sh10000, 32'sh10000, 32'sh20000, 32'sh10000, 1);
      send_points(32'sh10000, -32'sh10000, 32'sh20000, -32'sh10000, 1);
      send_points(32'sh10000, 0, 32'sh10000, 32'sh10000, 1);
      send_points(-32'sh10000, 0, -32'sh10000, 32'sh10000, 1);
      send_points(32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1);
      send_points(32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 1);
      send_points(32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 1);
      send_points(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFE, 32'sh7FFFFFFF, 1);
      send_points(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 1);
      send_points(0, 32'sh7FFFFFFF, 1, 32'sh7FFFFFFF, 1);
      send_points(1, 1, 2, 2, 1);
      send_points(-1, -1, 0, 0, 1);
      send_points(32'sh12345, 32'sh54321, 32'sh12346, 32'sh54321, 1);
      send_points(-32'sh1, 32'sh0, 32'sh0, -32'sh1, 0);

      // bursts run back to back inside; at least one idle cycle between bursts
      for (int i = 0; i < 1550; i += run) begin
         gap = $urandom_range(1, 12);
         repeat (gap) @(posedge clock);
         run = $urandom_range(1, 40);
         for (int j = 0; j < run; j++) begin
            x1 = pick_coord();
            y1 = pick_coord();
            if ($urandom_range(0, 19) == 0) begin
               x2 = x1; y2 = y1;
            end else if ($urandom_range(0, 3) == 0) begin
               // near neighbor: short segments stress normalization
               x2 = x1 + $signed($urandom_range(0, 16)) - 8;
               y2 = y1 + $signed($urandom_range(0, 16)) - 8;
            end else begin
               x2 = pick_coord();
               y2 = pick_coord();
            end
            send_points(x1, y1, x2, y2, j != run - 1);
         end
      end

      while (board.pending.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("[two_point_line_normal_form] OK");
      else
         $display("[two_point_line_normal_form] ERROR");
      $finish;
   end

endmodule
